// ===== hdl/bdq_pkg.sv =====
// Shared types and constants for the bounded deque with remove by value.
`timescale 1ns / 1ps

package bdq_pkg;

    // Store size and derived widths
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int VAL_W = 32;

    // Stream word layouts
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Request codes
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_REMOVE     = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // What a cell does on the next clock edge
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_TAKE_LEFT  = 2'd1,
        CELL_TAKE_RIGHT = 2'd2,
        CELL_LOAD       = 2'd3
    } t_cell_op;

endpackage

// ===== hdl/bounded_deque_with_remove_by_value.sv =====
// Top level of the bounded deque: request register, cell chain, control, result register.
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Word layout (low bit up)
// s_axis    in   s_axis_tvalid/tready      action[2:0], value[34:3], zero pad to 40
// m_axis    out  m_axis_tvalid/tready      status[1:0], removed_value[33:2],
//                                          entry_count[38:34], zero pad to 40
//
// A request is registered on acceptance; as it executes, all cells compare against
// the key in parallel, a find-first picks the earliest hit, and every cell shifts,
// loads or holds on the same edge: one request per cycle unless results stall.
// Reset (i_rst_n low, synchronous) empties the store and drops both pipeline words.
// A stalled result holds the request register; the input side keeps accepting
// as long as that register is free or drains in the same cycle.

module bounded_deque_with_remove_by_value (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // action[2:0], value[34:3], pad
    input  logic [bdq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status[1:0], removed_value[33:2], entry_count[38:34], pad
    output logic [bdq_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int D  = bdq_pkg::DEPTH;
    localparam int CW = bdq_pkg::CNT_W;
    localparam int IW = bdq_pkg::IDX_W;
    localparam int VW = bdq_pkg::VAL_W;

    logic                 r_req_valid;
    logic [2:0]           r_action;
    logic [VW-1:0]        r_value;
    logic [CW-1:0]        r_count;
    logic                 r_out_valid;
    logic [1:0]           r_status;
    logic [VW-1:0]        r_removed;
    logic [4:0]           r_count_out;

    logic                 exec_fire;
    logic                 in_fire;
    logic [CW-1:0]        n_count;
    logic [1:0]           n_status;
    logic [VW-1:0]        n_removed;

    bdq_pkg::t_cell_op    cell_op  [D];
    logic [VW-1:0]        cell_val [D];
    logic [D-1:0]         cell_match;
    logic [D-1:0]         occupied;
    logic [D-1:0]         hits;
    logic [D-1:0]         first_hit;
    logic [D-1:0]         from_hit;
    logic                 full;
    logic                 empty;
    logic [IW-1:0]        back_idx;

    assign exec_fire     = r_req_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_req_valid || exec_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Register the request word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_req_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action <= s_axis_tdata[2:0];
            r_value  <= s_axis_tdata[34:3];
        end
    end

    // Chain of cells, each fed by both neighbors
    for (genvar g = 0; g < D; g++) begin : g_cell
        logic [VW-1:0] left_in;
        logic [VW-1:0] right_in;

        if (g == 0) begin : g_first
            assign left_in = r_value;
        end else begin : g_mid_l
            assign left_in = cell_val[g-1];
        end

        if (g == D - 1) begin : g_last
            assign right_in = cell_val[g];
        end else begin : g_mid_r
            assign right_in = cell_val[g+1];
        end

        assign occupied[g] = (CW'(g) < r_count);

        bdq_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op[g]),
            .i_left  (left_in),
            .i_right (right_in),
            .i_key   (r_value),
            .o_value (cell_val[g]),
            .o_match (cell_match[g])
        );
    end

    // Earliest match from the front, and every cell at or behind it
    assign hits      = cell_match & occupied;
    assign first_hit = hits & (~hits + D'(1));
    assign from_hit  = ~(first_hit - D'(1));

    assign full     = (r_count == CW'(D));
    assign empty    = (r_count == '0);
    assign back_idx = IW'(r_count - CW'(1));

    // Decode the request into cell operations, status and new count
    always_comb begin
        n_count   = r_count;
        n_status  = bdq_pkg::ST_OK;
        n_removed = '0;
        for (int i = 0; i < D; i++) begin
            cell_op[i] = bdq_pkg::CELL_HOLD;
        end
        unique case (r_action)
            bdq_pkg::ACT_PUSH_FRONT: begin
                if (full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    for (int i = 0; i < D; i++) begin
                        cell_op[i] = bdq_pkg::CELL_TAKE_LEFT;
                    end
                end
            end
            bdq_pkg::ACT_PUSH_BACK: begin
                if (full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                    for (int i = 0; i < D; i++) begin
                        if (CW'(i) == r_count) begin
                            cell_op[i] = bdq_pkg::CELL_LOAD;
                        end
                    end
                end
            end
            bdq_pkg::ACT_POP_FRONT: begin
                if (empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_count   = r_count - CW'(1);
                    n_removed = cell_val[0];
                    for (int i = 0; i < D; i++) begin
                        cell_op[i] = bdq_pkg::CELL_TAKE_RIGHT;
                    end
                end
            end
            bdq_pkg::ACT_POP_BACK: begin
                if (empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_count   = r_count - CW'(1);
                    n_removed = cell_val[back_idx];
                end
            end
            bdq_pkg::ACT_REMOVE: begin
                if (empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else if (hits == '0) begin
                    n_status = bdq_pkg::ST_NOT_FOUND;
                end else begin
                    // the removed word equals the key
                    n_count   = r_count - CW'(1);
                    n_removed = r_value;
                    for (int i = 0; i < D; i++) begin
                        if (from_hit[i]) begin
                            cell_op[i] = bdq_pkg::CELL_TAKE_RIGHT;
                        end
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        // cells move only when the request executes
        if (!exec_fire) begin
            for (int i = 0; i < D; i++) begin
                cell_op[i] = bdq_pkg::CELL_HOLD;
            end
        end
    end

    // Advance the occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (exec_fire) begin
            r_count <= n_count;
        end
    end

    // Hold the result word until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_status    <= n_status;
            r_removed   <= n_removed;
            r_count_out <= 5'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_count_out, r_removed, r_status};

endmodule

// ===== hdl/bdq_cell.sv =====
// One storage cell of the deque chain: holds a value, shifts and compares.
`timescale 1ns / 1ps

module bdq_cell (
    input  logic                        i_clk,
    input  bdq_pkg::t_cell_op           i_op,
    input  logic [bdq_pkg::VAL_W-1:0]   i_left,
    input  logic [bdq_pkg::VAL_W-1:0]   i_right,
    input  logic [bdq_pkg::VAL_W-1:0]   i_key,
    output logic [bdq_pkg::VAL_W-1:0]   o_value,
    output logic                        o_match
);

    logic [bdq_pkg::VAL_W-1:0] r_value;

    // Take a neighbor's word, load the key, or hold
    always_ff @(posedge i_clk) begin
        case (i_op)
            bdq_pkg::CELL_TAKE_LEFT:  r_value <= i_left;
            bdq_pkg::CELL_TAKE_RIGHT: r_value <= i_right;
            bdq_pkg::CELL_LOAD:       r_value <= i_key;
            default:                  r_value <= r_value;
        endcase
    end

    assign o_value = r_value;
    assign o_match = (r_value == i_key);

endmodule

// ===== tb/tb.sv =====
// Testbench for the bounded deque with remove by value: stream driver, model and result check.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 60;
    localparam int TAIL_CYCLES  = 10;
    localparam int CYCLE_LIMIT  = 200000;

    // Stream biases for the random part
    localparam int BIAS_FILL  = 0;
    localparam int BIAS_DRAIN = 1;
    localparam int BIAS_MIXED = 2;

    // Request codes the block does not define; it must ignore them
    localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI  = 3'd7;

    typedef logic [bdq_pkg::VAL_W-1:0] t_value;

    typedef struct packed {
        logic [1:0]  status;
        t_value      removed;
        logic [4:0]  count;
    } t_deque_result;

    // Shadow deque: applies each accepted request word and queues the result it must produce
    class t_deque_scoreboard;
        t_value        cells [bdq_pkg::DEPTH];
        int unsigned   fill;
        t_deque_result due_q [$];
        int            errors;
        int            requests;
        int            checked;
        int            full_seen;
        int            empty_seen;
        int            miss_seen;
        int            peak_fill;

        function new();
            fill      = 0;
            errors    = 0;
            requests  = 0;
            checked   = 0;
            full_seen = 0;
            empty_seen = 0;
            miss_seen = 0;
            peak_fill = 0;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // Close the gap at pos, keeping the order of the entries behind it
        function void close_gap(int unsigned pos);
            for (int unsigned i = pos; i + 1 < fill; i++)
                cells[i] = cells[i + 1];
            fill--;
        endfunction

        function void note_request(logic [2:0] act, t_value val);
            t_deque_result res;
            int            hit;
            res.status  = bdq_pkg::ST_OK;
            res.removed = '0;
            hit         = -1;
            requests++;
            case (act)
                bdq_pkg::ACT_PUSH_FRONT: begin
                    if (fill >= bdq_pkg::DEPTH) begin
                        res.status = bdq_pkg::ST_FULL;
                    end else begin
                        for (int unsigned i = fill; i > 0; i--)
                            cells[i] = cells[i - 1];
                        cells[0] = val;
                        fill++;
                    end
                end
                bdq_pkg::ACT_PUSH_BACK: begin
                    if (fill >= bdq_pkg::DEPTH) begin
                        res.status = bdq_pkg::ST_FULL;
                    end else begin
                        cells[fill] = val;
                        fill++;
                    end
                end
                bdq_pkg::ACT_POP_FRONT: begin
                    if (fill == 0) begin
                        res.status = bdq_pkg::ST_EMPTY;
                    end else begin
                        res.removed = cells[0];
                        close_gap(0);
                    end
                end
                bdq_pkg::ACT_POP_BACK: begin
                    if (fill == 0) begin
                        res.status = bdq_pkg::ST_EMPTY;
                    end else begin
                        res.removed = cells[fill - 1];
                        fill--;
                    end
                end
                bdq_pkg::ACT_REMOVE: begin
                    if (fill == 0) begin
                        res.status = bdq_pkg::ST_EMPTY;
                    end else begin
                        // take the match nearest the front
                        for (int i = 0; i < int'(fill); i++) begin
                            if (hit < 0 && cells[i] == val)
                                hit = i;
                        end
                        if (hit >= 0) begin
                            res.removed = cells[hit];
                            close_gap(hit);
                        end else begin
                            res.status = bdq_pkg::ST_NOT_FOUND;
                        end
                    end
                end
                default: begin
                    // unused codes leave the store alone
                end
            endcase
            res.count = fill[4:0];
            if (int'(fill) > peak_fill)
                peak_fill = fill;
            due_q.push_back(res);
        endfunction

        function void check_result(logic [bdq_pkg::M_TDATA_W-1:0] word);
            t_deque_result want;
            logic [1:0]    got_status;
            t_value        got_removed;
            logic [4:0]    got_count;
            got_status  = word[1:0];
            got_removed = word[33:2];
            got_count   = word[38:34];
            if (due_q.size() == 0) begin
                $error("result word %h arrived with no request outstanding", word);
                errors++;
                return;
            end
            want = due_q.pop_front();
            checked++;
            case (got_status)
                bdq_pkg::ST_FULL:      full_seen++;
                bdq_pkg::ST_EMPTY:     empty_seen++;
                bdq_pkg::ST_NOT_FOUND: miss_seen++;
                default: ;
            endcase
            if (got_status !== want.status) begin
                $error("status mismatch: expected %0d, got %0d", want.status, got_status);
                errors++;
            end
            if (got_removed !== want.removed) begin
                $error("removed_value mismatch: expected %h, got %h",
                       want.removed, got_removed);
                errors++;
            end
            if (got_count !== want.count) begin
                $error("entry_count mismatch: expected %0d, got %0d", want.count, got_count);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // action[2:0], value[34:3], zero pad
    logic [bdq_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // status[1:0], removed_value[33:2], entry_count[38:34], zero pad
    logic [bdq_pkg::M_TDATA_W-1:0]   m_axis_tdata;

    int                              hold_token    = 0;
    t_deque_scoreboard               sb            = new();

    bounded_deque_with_remove_by_value uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Offer one request word and hold it until the block takes it
    task automatic send_request(logic [2:0] act, t_value val);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(bdq_pkg::S_TDATA_W - bdq_pkg::VAL_W - 3){1'b0}}, val, act};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sb.note_request(act, val);
    endtask

    task automatic idle_sender(int cycles);
        if (cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stop offering until every outstanding result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic t_value random_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            return t_value'($urandom_range(0, 6) - 3);
        else if (k < 8)
            return t_value'($urandom());
        else if (k == 8)
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        else
            return t_value'(1) << $urandom_range(0, 31);
    endfunction

    // Choose the next request word, leaning toward pushes or removals per bias
    task automatic pick_request(int bias, output logic [2:0] act, output t_value val);
        int r;
        int push_pct;
        r        = $urandom_range(0, 99);
        push_pct = (bias == BIAS_FILL) ? 70 : (bias == BIAS_DRAIN) ? 20 : 45;
        if (r < 3)
            act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        else if (r < 3 + push_pct)
            act = ($urandom_range(0, 1) != 0) ? bdq_pkg::ACT_PUSH_BACK
                                              : bdq_pkg::ACT_PUSH_FRONT;
        else
            case ($urandom_range(0, 4))
                0:       act = bdq_pkg::ACT_POP_FRONT;
                1:       act = bdq_pkg::ACT_POP_BACK;
                default: act = bdq_pkg::ACT_REMOVE;
            endcase
        if (act == bdq_pkg::ACT_REMOVE && sb.fill > 0 && $urandom_range(0, 9) < 6)
            val = sb.cells[$urandom_range(0, sb.fill - 1)];
        else
            val = random_value();
    endtask

    // Hold the receiver off while the sender keeps pushing, then again while it pops
    task automatic run_pressure();
        wait_drained();
        hold_token <= hold_token + 1;
        for (int i = 0; i < 20; i++)
            send_request(($urandom_range(0, 1) != 0) ? bdq_pkg::ACT_PUSH_BACK
                                                     : bdq_pkg::ACT_PUSH_FRONT,
                         random_value());
        wait_drained();
        hold_token <= hold_token + 1;
        for (int i = 0; i < 20; i++)
            send_request(($urandom_range(0, 1) != 0) ? bdq_pkg::ACT_POP_BACK
                                                     : bdq_pkg::ACT_POP_FRONT,
                         random_value());
        wait_drained();
    endtask

    // Receiver: switch among stall patterns, and honor hold-off requests
    initial begin : receiver
        int seen;
        int hold_left;
        int mode;
        int mode_left;
        int phase;
        seen      = 0;
        hold_left = 0;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (hold_token != seen) begin
                seen      = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 1) != 0);
                    default: m_axis_tready <= (phase % 4 == 0);
                endcase
            end
        end
    end

    // Check every result word the block hands over
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Give up after a generous number of cycles
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("bounded_deque_with_remove_by_value test failed");
        $finish;
    end

    initial begin : stimulus
        logic [2:0] act;
        t_value     val;
        int         bias;
        int         bias_left;
        int         burst;
        int         random_start;
        bit         pressed;
        bias      = BIAS_MIXED;
        bias_left = 0;
        pressed   = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty store, value extremes, duplicates, head/middle/tail removal,
        // absent value, unused codes
        send_request(bdq_pkg::ACT_POP_FRONT,  32'd0);
        send_request(bdq_pkg::ACT_POP_BACK,   32'd0);
        send_request(bdq_pkg::ACT_REMOVE,     32'd5);
        send_request(ACT_SPARE_LO,            32'hFFFF_FFFF);
        send_request(bdq_pkg::ACT_PUSH_BACK,  32'h7FFF_FFFF);
        send_request(bdq_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
        send_request(bdq_pkg::ACT_PUSH_BACK,  32'hFFFF_FFFF);
        send_request(bdq_pkg::ACT_PUSH_BACK,  32'h0000_0000);
        send_request(bdq_pkg::ACT_PUSH_FRONT, 32'd7);
        send_request(bdq_pkg::ACT_PUSH_BACK,  32'd7);
        send_request(bdq_pkg::ACT_REMOVE,     32'd7);
        send_request(bdq_pkg::ACT_REMOVE,     32'd99);
        send_request(bdq_pkg::ACT_REMOVE,     32'h8000_0000);
        send_request(bdq_pkg::ACT_POP_FRONT,  32'd0);
        send_request(bdq_pkg::ACT_POP_BACK,   32'd0);
        send_request(ACT_SPARE_MID,           32'h1234_5678);
        send_request(ACT_SPARE_HI,            32'd0);
        send_request(bdq_pkg::ACT_PUSH_FRONT, 32'h5555_5555);
        send_request(bdq_pkg::ACT_PUSH_BACK,  32'hAAAA_AAAA);
        send_request(bdq_pkg::ACT_REMOVE,     32'hFFFF_FFFF);
        send_request(bdq_pkg::ACT_REMOVE,     32'hAAAA_AAAA);
        send_request(bdq_pkg::ACT_POP_BACK,   32'd0);
        send_request(bdq_pkg::ACT_POP_FRONT,  32'd0);
        send_request(bdq_pkg::ACT_POP_FRONT,  32'd0);
        wait_drained();

        // Random bursts with random gaps; bias drifts between filling and draining
        random_start = sb.requests;
        while (sb.requests - random_start < RANDOM_ITEMS) begin
            if (!pressed && sb.requests - random_start >= RANDOM_ITEMS / 2) begin
                pressed = 1'b1;
                run_pressure();
            end
            if (bias_left <= 0) begin
                bias      = $urandom_range(0, 2);
                bias_left = $urandom_range(20, 60);
            end
            burst = $urandom_range(1, 16);
            for (int i = 0; i < burst; i++) begin
                pick_request(bias, act, val);
                send_request(act, val);
            end
            bias_left -= burst;
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 8));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests, %0d results checked, peak occupancy %0d.",
                 sb.requests, sb.checked, sb.peak_fill);
        $display("Statuses seen: full %0d, empty %0d, not found %0d.",
                 sb.full_seen, sb.empty_seen, sb.miss_seen);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("bounded_deque_with_remove_by_value test passed");
        else
            $display("bounded_deque_with_remove_by_value test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bdq_pkg.sv
hdl/bdq_cell.sv
hdl/bounded_deque_with_remove_by_value.sv
tb/tb.sv
